// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define CNR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/cnr_pkg.sv
// types, constants and the curve number table for the runoff core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cnr_pkg;

  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0] CloudCode = 8'd16;
  localparam logic [6:0] CnFull    = 7'd100;

  typedef enum logic [1:0] {
    REG_MOISTURE = 2'd0,
    REG_USE_RAIN = 2'd1,
    REG_DESIGN   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [6:0]  cn;
    logic [26:0] num;
    logic [15:0] rain;
  } cnr_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNQ,
    ST_S,
    ST_IA,
    ST_Q45,
    ST_MUL,
    ST_RUN,
    ST_SCALE,
    ST_DONE
  } back_state_e;

  localparam logic [6:0] CnTable [0:63] = '{
    7'd0, 7'd66, 7'd63, 7'd63, 7'd58, 7'd38, 7'd38, 7'd38,
    7'd30, 7'd38, 7'd25, 7'd0, 7'd0, 7'd0, 7'd72, 7'd77,
    7'd0, 7'd76, 7'd74, 7'd74, 7'd72, 7'd61, 7'd61, 7'd61,
    7'd58, 7'd61, 7'd55, 7'd0, 7'd0, 7'd0, 7'd79, 7'd86,
    7'd0, 7'd78, 7'd83, 7'd83, 7'd83, 7'd74, 7'd74, 7'd74,
    7'd71, 7'd74, 7'd70, 7'd0, 7'd0, 7'd0, 7'd85, 7'd91,
    7'd0, 7'd87, 7'd85, 7'd85, 7'd85, 7'd80, 7'd80, 7'd80,
    7'd78, 7'd80, 7'd77, 7'd0, 7'd0, 7'd0, 7'd88, 7'd94
  };

  function automatic logic [6:0] table_cn(input logic [7:0] lc, input logic [2:0] hs);
    logic [2:0] hm;
    logic [6:0] t;
    logic [6:0] r;
    hm = hs - 3'd1;
    t  = CnTable[{hm[1:0], lc[3:0]}];
    if (lc == 8'd0 || hs == 3'd0) begin
      r = 7'd0;
    end else if (hs inside {[3'd1:3'd4]} && lc < 8'd16 && t != 7'd0) begin
      r = t;
    end else if (lc inside {[8'd11:8'd13]}) begin
      r = CnFull;
    end else if (hs == 3'd5) begin
      r = CnFull;
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/curve_number_runoff_core.sv
// Curve-number runoff core. Each input transfer carries one raster cell (land cover, soil
// group, rainfall); each output transfer carries its runoff, a write flag and the table
// curve number. The front takes one cell per cycle, while the queue is not full, through
// a three-stage classifier into a small queue, so while the back is busy up to the queue
// depth plus three cells are absorbed. The back does the blend division by ten and the rain
// scaling by reciprocal multiplication, splits the retention into initial abstraction and
// 4S/5 by a digit-serial division by five, and runs the retention and the runoff quotient
// on one 64-step restoring divider. The back takes a new cell only after the last result
// has been loaded into the output register, which waits on m_axis_tready. Config writes
// are to be made only while idle; the core itself does not enforce this.
// depends on cnr_pkg, cnr_front, cnr_fifo, cnr_back
`timescale 1ns / 1ps
`default_nettype none
module curve_number_runoff_core
  import cnr_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // land_cover, soil_group, rain_hundredths
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // runoff_hundredths, write_valid, curve_number
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  logic [4:0]  moist_q;
  logic        use_rain_q;
  logic [15:0] design_q;
  logic        push, full, pop, qvalid;
  cnr_item_t   qin, qout;
  logic [15:0] runoff;
  logic        wv;
  logic [6:0]  cn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moist_q    <= 5'd20;
      use_rain_q <= 1'b0;
      design_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MOISTURE: moist_q    <= cfg_data_i[4:0];
        REG_USE_RAIN: use_rain_q <= cfg_data_i[0];
        REG_DESIGN:   design_q   <= cfg_data_i;
        default:      design_q   <= design_q;
      endcase
    end
  end

  cnr_front u_front (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .land_cover_i(s_axis_tdata[7:0]), .soil_group_i(s_axis_tdata[10:8]),
    .rain_hundredths_i(s_axis_tdata[26:11]),
    .moisture_i(moist_q), .use_rain_i(use_rain_q), .design_rain_i(design_q),
    .push_o(push), .item_o(qin), .full_i(full)
  );

  cnr_fifo #(.Depth(QueueDepth), .Width($bits(cnr_item_t))) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(qin), .full_o(full),
    .pop_i(pop), .data_o(qout), .valid_o(qvalid)
  );

  cnr_back u_back (
    .clk_i, .rst_ni, .item_valid_i(qvalid), .item_i(qout), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .runoff_o(runoff), .write_valid_o(wv), .cn_o(cn)
  );

  assign m_axis_tdata = {cn, wv, runoff};
endmodule
`default_nettype wire

// File: hw/rtl/cnr_fifo.sv
// small register queue between front and back
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cnr_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  valid_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] incr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? incr(wptr_q) : wptr_q;
    rptr_d = pop_i ? incr(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `CNR_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `CNR_ASSERT(a_no_underflow, pop_i |-> valid_o, "pop from empty queue")
  `CNR_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CntW'(Depth), "queue count out of range")
endmodule
`default_nettype wire

// File: hw/rtl/cnr_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cnr_div #(
  parameter int unsigned DividendW = 64,
  parameter int unsigned DivisorW  = 48
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(DividendW);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [DividendW-1:0] quo_q;
  logic [DivisorW:0]    rem_q;
  logic [DivisorW-1:0]  div_q;
  logic [DivisorW:0]    rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q[DivisorW-1:0], quo_q[DividendW-1]};
  assign ge     = (rem_sh >= {1'b0, div_q});
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DividendW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sh - {1'b0, div_q} : rem_sh;
      quo_q <= {quo_q[DividendW-2:0], ge};
    end
  end

  `CNR_ASSERT(a_start_idle, start_i |-> !busy_q, "divider started while busy")
  `CNR_ASSERT(a_done_after_busy, done_o |-> $past(busy_q) && !busy_q, "stray done")
  `CNR_ASSERT(a_start_done, start_i |=> busy_q && !done_o, "divider failed to start")
endmodule
`default_nettype wire

// File: hw/rtl/cnr_front.sv
// front: cloud substitution, table lookup, moisture blend numerator
// depends on cnr_pkg
`timescale 1ns / 1ps
`default_nettype none
module cnr_front
  import cnr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [7:0]  land_cover_i,
  input  wire logic [2:0]  soil_group_i,
  input  wire logic [15:0] rain_hundredths_i,
  input  wire logic [4:0]  moisture_i,
  input  wire logic        use_rain_i,
  input  wire logic [15:0] design_rain_i,
  output logic             push_o,
  output cnr_item_t        item_o,
  input  wire logic        full_i
);
  logic        en;
  logic [7:0]  last_lc_q, lc;
  logic        va_q, vb_q, vc_q;
  logic [6:0]  cn_a_q, cn_b_q, cn_c_q;
  logic [13:0] cn2_a_q;
  logic [15:0] rain_a_q, rain_b_q, rain_c_q;
  logic [22:0] x_b_q;
  logic [26:0] num_c_q;
  logic [4:0]  m;
  logic [3:0]  w;
  logic        dry;
  logic [6:0]  cn_tab;
  logic [23:0] x_d;
  logic [26:0] num_d;

  assign en      = !vc_q || !full_i;
  assign ready_o = en;
  assign push_o  = vc_q && en;
  assign item_o  = '{cn: cn_c_q, num: num_c_q, rain: rain_c_q};

  always_comb begin
    lc     = (land_cover_i == CloudCode) ? last_lc_q : land_cover_i;
    cn_tab = table_cn(lc, soil_group_i);
    m      = (moisture_i < 5'd10) ? 5'd10 : ((moisture_i > 5'd30) ? 5'd30 : moisture_i);
    dry    = (m < 5'd20);
    w      = dry ? 4'(5'd20 - m) : 4'(m - 5'd20);
    if (dry) begin
      x_d = 24'd147056 + 24'(cn_a_q) * 24'd10812 + 24'(cn2_a_q) * 24'd504;
    end else begin
      x_d = 24'd454210 + 24'(cn_a_q) * 24'd104595 - 24'(cn2_a_q) * 24'd442;
    end
    num_d = ((27'(4'd10 - w) * 27'(cn_b_q)) << 16) + 27'(w) * 27'(x_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lc_q <= '0;
      va_q      <= 1'b0;
      vb_q      <= 1'b0;
      vc_q      <= 1'b0;
    end else if (en) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      if (valid_i && land_cover_i != CloudCode) begin
        last_lc_q <= land_cover_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cn_a_q   <= cn_tab;
      cn2_a_q  <= 14'(cn_tab) * 14'(cn_tab);
      rain_a_q <= use_rain_i ? rain_hundredths_i : design_rain_i;
      cn_b_q   <= cn_a_q;
      rain_b_q <= rain_a_q;
      x_b_q    <= x_d[22:0];
      cn_c_q   <= cn_b_q;
      rain_c_q <= rain_b_q;
      num_c_q  <= num_d;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/cnr_back.sv
// back: retention, initial abstraction and runoff on a shared divider
// depends on cnr_pkg and cnr_div
`timescale 1ns / 1ps
`default_nettype none
module cnr_back
  import cnr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        item_valid_i,
  input  cnr_item_t        item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      runoff_o,
  output logic             write_valid_o,
  output logic [6:0]       cn_o
);
  localparam logic [63:0] SNum      = 64'd1000 << 32;
  localparam logic [41:0] STen      = 42'd655360;
  localparam logic [31:0] RecipTen  = 32'hCCCCCCCD;
  localparam logic [31:0] RecipHund = 32'h51EB851F;
  localparam logic [20:0] RecipFive = 21'd419431;

  back_state_e state_q, state_d;
  logic        launched_q, start, done;
  logic [63:0] dividend, quot;
  logic [47:0] divisor;
  logic [6:0]  cn_q;
  logic [26:0] num_q, cnq_q, cnq_d;
  logic [15:0] rain_q;
  logic [41:0] s_q, ia_q;
  logic [25:0] p_q, p_d, d;
  logic [42:0] den_q, den_d;
  logic [51:0] dd_q;
  logic [25:0] run_q;
  logic [32:0] prod_q;
  logic        zero_q, wv_q;
  logic        out_valid_q, out_wv_q, load;
  logic [15:0] out_runoff_q, runoff;
  logic [6:0]  out_cn_q;
  logic [41:0] s_raw;
  logic [58:0] ten_prod;
  logic [63:0] hund_prod;
  logic [1:0]  dig_q;
  logic [2:0]  r5_q, r5_d;
  logic [47:0] s_ext;
  logic [15:0] digit, q5;
  logic [18:0] v5;
  logic [39:0] five_prod;
  logic [1:0]  frac;

  cnr_div #(.DividendW(64), .DivisorW(48)) u_div (
    .clk_i, .rst_ni, .start_i(start), .dividend_i(dividend), .divisor_i(divisor),
    .done_o(done), .quot_o(quot)
  );

  assign d     = p_q - ia_q[25:0];
  assign s_raw = quot[41:0];
  assign load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign runoff = (zero_q || prod_q[32]) ? (zero_q ? 16'd0 : 16'hFFFF) : prod_q[31:16];

  // blend division by ten and rain scaling by reciprocal multiplication
  assign ten_prod  = 59'(num_q) * 59'(RecipTen);
  assign cnq_d     = 27'(ten_prod[58:35]);
  assign hund_prod = 64'({rain_q, 16'd0}) * 64'(RecipHund);
  assign p_d       = hund_prod[62:37];

  // s / 5 one 16-bit digit per cycle, remainder gives the fraction of 4s/5
  always_comb begin
    s_ext = {6'd0, s_q};
    case (dig_q)
      2'd0:    digit = s_ext[47:32];
      2'd1:    digit = s_ext[31:16];
      default: digit = s_ext[15:0];
    endcase
    v5        = {r5_q, digit};
    five_prod = 40'(v5) * 40'(RecipFive);
    q5        = five_prod[36:21];
    r5_d      = 3'(v5 - 19'(q5) * 19'd5);
    case (r5_q)
      3'd2:    frac = 2'd1;
      3'd3:    frac = 2'd2;
      3'd4:    frac = 2'd3;
      default: frac = 2'd0;
    endcase
    den_d = 43'(44'(p_q) + {ia_q, 2'b00} + 44'(frac));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (item_valid_i) state_d = ST_CNQ;
      ST_CNQ:   state_d = (cnq_d == '0) ? ST_DONE : ST_S;
      ST_S:     if (done) state_d = ST_IA;
      ST_IA:    if (dig_q == 2'd2) state_d = ST_Q45;
      ST_Q45:   state_d = (ia_q >= 42'(p_q)) ? ST_DONE : ST_MUL;
      ST_MUL:   state_d = ST_RUN;
      ST_RUN:   if (done) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == ST_IDLE) && item_valid_i;
    dividend = '0;
    divisor  = '0;
    case (state_q)
      ST_S: begin
        dividend = SNum;
        divisor  = 48'(cnq_q);
      end
      ST_RUN: begin
        dividend = 64'(dd_q);
        divisor  = 48'(den_q);
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
    start = !launched_q && (state_q inside {ST_S, ST_RUN});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        launched_q <= 1'b1;
      end else if (done) begin
        launched_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cn_q   <= item_i.cn;
      num_q  <= item_i.num;
      rain_q <= item_i.rain;
      zero_q <= 1'b1;
    end
    if (state_q == ST_CNQ) begin
      cnq_q <= cnq_d;
      p_q   <= p_d;
      wv_q  <= (cnq_d != '0);
    end
    if (done && state_q == ST_S) begin
      s_q   <= (s_raw > STen) ? s_raw - STen : '0;
      dig_q <= 2'd0;
      r5_q  <= 3'd0;
    end
    if (state_q == ST_IA) begin
      ia_q  <= {ia_q[25:0], q5};
      r5_q  <= r5_d;
      dig_q <= dig_q + 2'd1;
    end
    if (state_q == ST_Q45) begin
      den_q <= den_d;
    end
    if (state_q == ST_MUL) begin
      dd_q <= 52'(d) * 52'(d);
    end
    if (done && state_q == ST_RUN) begin
      run_q <= quot[25:0];
    end
    if (state_q == ST_SCALE) begin
      prod_q <= 33'(run_q) * 33'd100;
      zero_q <= 1'b0;
    end
    if (load) begin
      out_runoff_q <= runoff;
      out_wv_q     <= wv_q;
      out_cn_q     <= cn_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign runoff_o      = out_runoff_q;
  assign write_valid_o = out_wv_q;
  assign cn_o          = out_cn_q;
endmodule
`default_nettype wire
